[rtl/i2csw_pkg.sv]
// ---------------------------------------------------------------------------
// I2C slave write receiver package
// Frame phase codes, configuration register indexes and the result word.
// ---------------------------------------------------------------------------
`default_nettype none

package i2csw_pkg;

    localparam int unsigned ADDR_W   = 7;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CFG_W    = 8;
    localparam int unsigned CFG_IDX_W = 2;

    // Reset values of the configuration registers.
    localparam logic [ADDR_W-1:0] OWN_ADDRESS_RST     = 7'h7B;
    localparam logic              LSB_FIRST_RST       = 1'b1;
    localparam logic [BYTE_W-1:0] BYTES_PER_FRAME_RST = 8'd2;
    localparam logic              NACK_ON_ZERO_RST    = 1'b1;

    // Bit counter codes: 0..7 data bits, then the two halves of the ACK clock.
    localparam logic [3:0] BIT_LAST     = 4'd7;
    localparam logic [3:0] BIT_ACK_WAIT = 4'd8;
    localparam logic [3:0] BIT_ACK_CLK  = 4'd9;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_OWN_ADDRESS     = 2'd0;
    localparam cfg_index_t REG_LSB_FIRST       = 2'd1;
    localparam cfg_index_t REG_BYTES_PER_FRAME = 2'd2;
    localparam cfg_index_t REG_NACK_ON_ZERO    = 2'd3;

    typedef enum logic [7:0] {
        PH_IDLE      = 8'b0000_0001,
        PH_ADDR      = 8'b0000_0010,
        PH_DATA      = 8'b0000_0100,
        PH_SKIP      = 8'b0000_1000,
        PH_ACK_DATA  = 8'b0001_0000,
        PH_ACK_BYTE  = 8'b0010_0000,
        PH_NACK_BYTE = 8'b0100_0000,
        PH_ACK_READ  = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic              sda_release;
        logic              byte_valid;
        logic [BYTE_W-1:0] data_byte;
        logic              address_hit;
        logic              read_request;
        logic              frame_end;
    } result_t;

endpackage

`default_nettype wire

[rtl/i2c_slave_write_receiver.sv]
// ---------------------------------------------------------------------------
// I2C slave write receiver
// Oversampled 7-bit address I2C slave that takes one SCL/SDA sample per word
// and returns one status word per sample: ACK drive, data bytes, address hit,
// R/W flag and stop pulse.
// ---------------------------------------------------------------------------
//
//  Channel   Handshake                 Payload
//  -------   -----------------------   ---------------------------------------
//  input     in_valid / in_stall       scl_sample, sda_sample
//  output    out_valid / out_stall     sda_release, byte_valid, data_byte,
//                                      address_hit, read_request, frame_end
//  config    cfg_write                 cfg_index, cfg_data
//
//  One sample word is accepted every cycle while in_stall is low; its result
//  word is registered. Bus decoding is a single pass through the phase register,
//  bit counter and shift register. A two-entry output buffer (output register
//  plus skid register) absorbs stalls; in_stall rises only when both are full.
//  Reset is asynchronous, active low, and returns the bus logic to idle with the
//  line released and the configuration to its defaults.
//
`default_nettype none

module i2c_slave_write_receiver (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          scl_sample,
    input  wire logic                          sda_sample,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               sda_release,
    output logic                               byte_valid,
    output logic [i2csw_pkg::BYTE_W-1:0]       data_byte,
    output logic                               address_hit,
    output logic                               read_request,
    output logic                               frame_end,
    input  wire logic                          cfg_write,
    input  wire i2csw_pkg::cfg_index_t         cfg_index,
    input  wire logic [i2csw_pkg::CFG_W-1:0]   cfg_data
);

    import i2csw_pkg::*;

    // Configuration registers.
    logic [ADDR_W-1:0] own_address_reg;
    logic              lsb_first_reg;
    logic [BYTE_W-1:0] bytes_per_frame_reg;
    logic              nack_on_zero_reg;

    // Bus state.
    logic              last_scl_reg, last_scl_next;
    logic              last_sda_reg, last_sda_next;
    phase_t            phase_reg, phase_next;
    logic [3:0]        bit_index_reg, bit_index_next;
    logic [BYTE_W-1:0] shift_byte_reg, shift_byte_next;
    logic [BYTE_W-1:0] accepted_count_reg, accepted_count_next;
    logic              rw_flag_reg, rw_flag_next;
    logic              hold_low_reg, hold_low_next;

    // Output buffer.
    result_t           out_word_reg, out_word_next;
    logic              out_valid_reg, out_valid_next;
    result_t           skid_word_reg, skid_word_next;
    logic              skid_valid_reg, skid_valid_next;

    result_t           result;
    logic              in_acc;
    logic              out_acc;
    logic              scl_high, scl_rise, scl_fall;
    logic              start_cond, stop_cond;
    logic              ack_phase;
    logic              byte_ok;
    logic [BYTE_W-1:0] shifted;

    assign in_stall = skid_valid_reg;
    assign in_acc   = in_valid && !skid_valid_reg;
    assign out_acc  = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg     <= OWN_ADDRESS_RST;
            lsb_first_reg       <= LSB_FIRST_RST;
            bytes_per_frame_reg <= BYTES_PER_FRAME_RST;
            nack_on_zero_reg    <= NACK_ON_ZERO_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_OWN_ADDRESS:     own_address_reg     <= cfg_data[ADDR_W-1:0];
                REG_LSB_FIRST:       lsb_first_reg       <= cfg_data[0];
                REG_BYTES_PER_FRAME: bytes_per_frame_reg <= cfg_data[BYTE_W-1:0];
                REG_NACK_ON_ZERO:    nack_on_zero_reg    <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        scl_high   = last_scl_reg && scl_sample;
        scl_rise   = !last_scl_reg && scl_sample;
        scl_fall   = last_scl_reg && !scl_sample;
        start_cond = scl_high && last_sda_reg && !sda_sample;
        stop_cond  = scl_high && !last_sda_reg && sda_sample;
        ack_phase  = (phase_reg == PH_ACK_DATA) || (phase_reg == PH_ACK_BYTE) ||
                     (phase_reg == PH_NACK_BYTE) || (phase_reg == PH_ACK_READ);

        if (lsb_first_reg)
        begin
            shifted = shift_byte_reg |
                      (BYTE_W'(sda_sample) << bit_index_reg[2:0]);
        end
        else
        begin
            shifted = {shift_byte_reg[BYTE_W-2:0], sda_sample};
        end

        byte_ok = (accepted_count_reg < bytes_per_frame_reg) &&
                  !(nack_on_zero_reg && (shifted == '0));

        phase_next          = phase_reg;
        bit_index_next      = bit_index_reg;
        shift_byte_next     = shift_byte_reg;
        accepted_count_next = accepted_count_reg;
        rw_flag_next        = rw_flag_reg;
        hold_low_next       = hold_low_reg;
        last_scl_next       = scl_sample;
        last_sda_next       = sda_sample;

        result             = '0;

        priority if (start_cond)
        begin
            phase_next          = PH_ADDR;
            bit_index_next      = '0;
            shift_byte_next     = '0;
            accepted_count_next = '0;
            rw_flag_next        = 1'b0;
            hold_low_next       = 1'b0;
        end
        else if (stop_cond)
        begin
            phase_next       = PH_IDLE;
            bit_index_next   = '0;
            hold_low_next    = 1'b0;
            result.frame_end = 1'b1;
        end
        else if (scl_rise && (phase_reg == PH_ADDR) && (bit_index_reg < BIT_ACK_WAIT))
        begin
            if (bit_index_reg < BIT_LAST)
            begin
                shift_byte_next = shifted;
                bit_index_next  = bit_index_reg + 4'd1;
            end
            else
            begin
                // The last clock of the address byte carries the R/W bit; the address is complete.
                rw_flag_next   = sda_sample;
                bit_index_next = BIT_ACK_WAIT;
                if (shift_byte_reg[ADDR_W-1:0] == own_address_reg)
                begin
                    result.address_hit = 1'b1;
                    phase_next = sda_sample ? PH_ACK_READ : PH_ACK_DATA;
                end
                else
                begin
                    phase_next = PH_SKIP;
                end
            end
        end
        else if (scl_rise && (phase_reg == PH_DATA) && (bit_index_reg < BIT_ACK_WAIT))
        begin
            shift_byte_next = shifted;
            bit_index_next  = bit_index_reg + 4'd1;
            if (bit_index_reg == BIT_LAST)
            begin
                if (byte_ok)
                begin
                    result.byte_valid   = 1'b1;
                    result.data_byte    = shifted;
                    accepted_count_next = accepted_count_reg + 8'd1;
                    phase_next          = PH_ACK_BYTE;
                end
                else
                begin
                    phase_next = PH_NACK_BYTE;
                end
            end
        end
        else if (scl_fall && ack_phase)
        begin
            if (bit_index_reg == BIT_ACK_WAIT)
            begin
                // Falling edge opens the ACK clock; pull low unless NACKing.
                hold_low_next  = (phase_reg != PH_NACK_BYTE);
                bit_index_next = BIT_ACK_CLK;
            end
            else
            begin
                hold_low_next   = 1'b0;
                bit_index_next  = '0;
                shift_byte_next = '0;
                phase_next      = (phase_reg == PH_ACK_READ) ? PH_SKIP : PH_DATA;
            end
        end
        else
        begin
        end

        result.sda_release  = !hold_low_next;
        result.read_request = rw_flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_scl_reg       <= 1'b1;
            last_sda_reg       <= 1'b1;
            phase_reg          <= PH_IDLE;
            bit_index_reg      <= '0;
            shift_byte_reg     <= '0;
            accepted_count_reg <= '0;
            rw_flag_reg        <= 1'b0;
            hold_low_reg       <= 1'b0;
        end
        else if (in_acc)
        begin
            last_scl_reg       <= last_scl_next;
            last_sda_reg       <= last_sda_next;
            phase_reg          <= phase_next;
            bit_index_reg      <= bit_index_next;
            shift_byte_reg     <= shift_byte_next;
            accepted_count_reg <= accepted_count_next;
            rw_flag_reg        <= rw_flag_next;
            hold_low_reg       <= hold_low_next;
        end
    end

    // The skid register only fills while the output register is held.
    always_comb
    begin
        out_word_next   = out_word_reg;
        out_valid_next  = out_valid_reg;
        skid_word_next  = skid_word_reg;
        skid_valid_next = skid_valid_reg;

        if (!out_valid_reg || out_acc)
        begin
            if (skid_valid_reg)
            begin
                out_word_next   = skid_word_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_word_next  = result;
                out_valid_next = in_acc;
            end
        end
        else if (in_acc)
        begin
            skid_word_next  = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign out_valid    = out_valid_reg;
    assign sda_release  = out_word_reg.sda_release;
    assign byte_valid   = out_word_reg.byte_valid;
    assign data_byte    = out_word_reg.data_byte;
    assign address_hit  = out_word_reg.address_hit;
    assign read_request = out_word_reg.read_request;
    assign frame_end    = out_word_reg.frame_end;

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a word while the output register is empty");

    a_hold_in_ack: assert property (@(posedge clk) disable iff (!rst_n)
        hold_low_reg |-> ((phase_reg == PH_ACK_DATA) || (phase_reg == PH_ACK_BYTE) ||
                          (phase_reg == PH_ACK_READ)))
        else $error("data line held low outside an acknowledged ACK clock");

    a_bit_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_index_reg <= BIT_ACK_CLK)
        else $error("bit counter out of range");

    a_byte_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && result.byte_valid) |=> (accepted_count_reg != '0))
        else $error("accepted data byte was not counted");
`endif

endmodule

`default_nettype wire
